### src/jvm_pkg.sv
package jvm_pkg;

   // Gain applied to the offset from mid, and the width that holds it.
   localparam int GAIN_FAST = 1600;
   localparam int GAIN_SLOW = 800;
   localparam int GAIN_BITS = 11;

   // A half-range below the floor is replaced by the substitute.
   localparam int RANGE_FLOOR = 500;
   localparam int RANGE_SUBST = 1800;

   // Calibration registers are never narrower than the reset values need.
   localparam int CAL_MIN_BITS = 12;

   // Limits of a 16-bit two's complement result, as magnitudes.
   localparam int SAT_POS_MAG = 32767;
   localparam int SAT_NEG_MAG = 32768;

   localparam int CSR_INDEX_BITS = 3;
   localparam int DEADBAND_BITS  = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_X_MIN     = 3'd0,
      CSR_X_MAX     = 3'd1,
      CSR_X_MID     = 3'd2,
      CSR_Y_MIN     = 3'd3,
      CSR_Y_MAX     = 3'd4,
      CSR_Y_MID     = 3'd5,
      CSR_DEADBAND  = 3'd6,
      CSR_FAST_MODE = 3'd7
   } csr_index_type;

   // Reset values of the calibration registers.
   localparam int RST_X_MIN     = 23;
   localparam int RST_X_MAX     = 4095;
   localparam int RST_X_MID     = 2050;
   localparam int RST_Y_MIN     = 16;
   localparam int RST_Y_MAX     = 4056;
   localparam int RST_Y_MID     = 1950;
   localparam int RST_DEADBAND  = 120;
   localparam int RST_FAST_MODE = 1;

endpackage

### src/jvm_front.sv
// Front end of one axis: side selection, distance and half-range in the first
// stage, gain multiplication in the second.
module jvm_front #(
   parameter int SAMPLE_BITS = 12,
   localparam int CW = (SAMPLE_BITS > jvm_pkg::CAL_MIN_BITS) ? SAMPLE_BITS
                                                            : jvm_pkg::CAL_MIN_BITS,
   localparam int NW = CW + jvm_pkg::GAIN_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [CW-1:0]          cal_min,
   input  logic [CW-1:0]          cal_mid,
   input  logic [CW-1:0]          cal_max,
   input  logic                   fast_mode,
   output logic                   out_valid,
   output logic                   out_above,
   output logic [NW-1:0]          out_num,
   output logic [CW-1:0]          out_range
);

   logic [CW-1:0] samp_ext;
   logic          above_in;
   logic [CW-1:0] dist_in;
   logic [CW:0]   span;
   logic [CW-1:0] range_in;

   logic          v1_ff, above1_ff;
   logic [CW-1:0] dist1_ff, range1_ff;
   logic          v2_ff, above2_ff;
   logic [NW-1:0] num2_ff;
   logic [CW-1:0] range2_ff;

   logic [jvm_pkg::GAIN_BITS-1:0] gain;
   logic [NW-1:0]                 num_in;

   always_comb begin
      samp_ext = CW'(sample);
      above_in = samp_ext > cal_mid;
      if (above_in) begin
         dist_in = samp_ext - cal_mid;
         span    = {1'b0, cal_max} - {1'b0, cal_mid};
      end else begin
         dist_in = cal_mid - samp_ext;
         span    = {1'b0, cal_mid} - {1'b0, cal_min};
      end
      // A negative span, from inverted calibration, also falls below the floor.
      if ($signed(span) < $signed((CW+1)'(jvm_pkg::RANGE_FLOOR))) begin
         range_in = CW'(jvm_pkg::RANGE_SUBST);
      end else begin
         range_in = span[CW-1:0];
      end
   end

   always_comb begin
      gain   = fast_mode ? jvm_pkg::GAIN_BITS'(jvm_pkg::GAIN_FAST)
                         : jvm_pkg::GAIN_BITS'(jvm_pkg::GAIN_SLOW);
      num_in = NW'(gain) * NW'(dist1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      above1_ff <= above_in;
      dist1_ff  <= dist_in;
      range1_ff <= range_in;
      above2_ff <= above1_ff;
      num2_ff   <= num_in;
      range2_ff <= range1_ff;
   end

   assign out_valid = v2_ff;
   assign out_above = above2_ff;
   assign out_num   = num2_ff;
   assign out_range = range2_ff;

endmodule

### src/jvm_div.sv
// Pipelined restoring divider: one quotient bit per stage, one stage per
// numerator bit. A tag travels alongside each word.
module jvm_div #(
   parameter int NW = 23,
   parameter int DW = 12,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [TW-1:0] out_tag
);

   logic          vld_ff [NW];
   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] nq_ff  [NW];
   logic [DW-1:0] den_ff [NW];
   logic [TW-1:0] tag_ff [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic          vld_prev;
      logic [DW-1:0] rem_prev;
      logic [NW-1:0] nq_prev;
      logic [DW-1:0] den_prev;
      logic [TW-1:0] tag_prev;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] nq_in;

      if (k == 0) begin : g_first
         assign vld_prev = in_valid;
         assign rem_prev = '0;
         assign nq_prev  = in_num;
         assign den_prev = in_den;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign tag_prev = tag_ff[k-1];
      end

      // The numerator shifts out at the top while quotient bits enter below.
      always_comb begin
         trial = {rem_prev, nq_prev[NW-1]};
         ge    = trial >= {1'b0, den_prev};
         if (ge) begin
            rem_in = DW'(trial - {1'b0, den_prev});
         end else begin
            rem_in = trial[DW-1:0];
         end
         nq_in = {nq_prev[NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
         rem_ff[k] <= rem_in;
         nq_ff[k]  <= nq_in;
         den_ff[k] <= den_prev;
         tag_ff[k] <= tag_prev;
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quo   = nq_ff[NW-1];
   assign out_tag   = tag_ff[NW-1];

endmodule

### src/jvm_back.sv
// Back end: deadband, offset, sign and saturation for both axes.
module jvm_back #(
   parameter int NW = 23
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid_x,
   input  logic                              valid_y,
   input  logic [NW-1:0]                     q_x,
   input  logic [NW-1:0]                     q_y,
   input  logic                              above_x,
   input  logic                              above_y,
   input  logic [jvm_pkg::DEADBAND_BITS-1:0] deadband,
   output logic                              out_valid,
   output logic signed [15:0]                vel_x,
   output logic signed [15:0]                vel_y
);

   localparam int MW = NW + 1;

   function automatic logic signed [15:0] sat_mag(input logic [MW-1:0] mag,
                                                  input logic neg);
      logic signed [15:0] res;
      if (neg) begin
         if (mag > MW'(jvm_pkg::SAT_NEG_MAG)) begin
            res = 16'sh8000;
         end else begin
            res = 16'(16'd0 - mag[15:0]);
         end
      end else begin
         if (mag > MW'(jvm_pkg::SAT_POS_MAG)) begin
            res = 16'sh7FFF;
         end else begin
            res = mag[15:0];
         end
      end
      return res;
   endfunction

   logic [NW-1:0]      dz_ext;
   logic [MW-1:0]      sum_x, diff_y;
   logic signed [15:0] vel_x_in, vel_y_in;
   logic               valid_ff;
   logic signed [15:0] vel_x_ff, vel_y_ff;

   always_comb begin
      dz_ext = NW'(deadband);
      sum_x  = {1'b0, q_x} + MW'(dz_ext);
      diff_y = MW'(q_y - dz_ext);
      if (q_x < dz_ext) begin
         vel_x_in = '0;
      end else begin
         vel_x_in = sat_mag(sum_x, above_x);
      end
      // For the y axis, as for the x axis, a sample above mid gives a negative command.
      if (q_y < dz_ext) begin
         vel_y_in = '0;
      end else begin
         vel_y_in = sat_mag(diff_y, above_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_x & valid_y;
      end
      vel_x_ff <= vel_x_in;
      vel_y_ff <= vel_y_in;
   end

   assign out_valid = valid_ff;
   assign vel_x     = vel_x_ff;
   assign vel_y     = vel_y_ff;

endmodule

### src/joystick_velocity_mapper_core.sv
// Channel   Direction  Ports                                      Handshake
// request   in         req_x_sample, req_y_sample                 start & !busy
// response  out        rsp_vel_x, rsp_vel_y                       rsp_valid strobe
// csr       in         csr_index, csr_wdata                       csr_valid & csr_ready
//
// A word is accepted on every cycle in which start is high; busy never rises.
// With CW the larger of SAMPLE_BITS and 12, a response word passes through two
// front stages, CW + 11 divider stages that each resolve one quotient bit, and
// one output stage.
// Reset is synchronous; it clears the pipeline valid bits and restores the
// calibration registers. Nothing stalls, as the receiver always takes the word.
module joystick_velocity_mapper_core #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [SAMPLE_BITS-1:0]               req_x_sample,
   input  logic [SAMPLE_BITS-1:0]               req_y_sample,
   output logic                                 rsp_valid,
   output logic signed [15:0]                   rsp_vel_x,
   output logic signed [15:0]                   rsp_vel_y,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jvm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [SAMPLE_BITS-1:0]               csr_wdata
);

   // Calibration registers are at least twelve bits wide so that their reset
   // values survive unchanged at narrow sample widths; writes are limited to
   // the sample width.
   localparam int CW = (SAMPLE_BITS > jvm_pkg::CAL_MIN_BITS) ? SAMPLE_BITS
                                                           : jvm_pkg::CAL_MIN_BITS;
   localparam int NW = CW + jvm_pkg::GAIN_BITS;

   logic [CW-1:0] x_min_ff, x_max_ff, x_mid_ff;
   logic [CW-1:0] y_min_ff, y_max_ff, y_mid_ff;
   logic [jvm_pkg::DEADBAND_BITS-1:0] deadband_ff;
   logic fast_mode_ff;

   logic csr_write;
   logic accept;

   logic          fx_valid, fx_above, fy_valid, fy_above;
   logic [NW-1:0] fx_num, fy_num;
   logic [CW-1:0] fx_range, fy_range;

   logic          dx_valid, dy_valid;
   logic [NW-1:0] dx_quo, dy_quo;
   logic          dx_above, dy_above;

   // The pipeline never stalls, so requests and register writes are always
   // taken.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;
   assign csr_write = csr_valid & csr_ready;

   // The user must make register writes only while the pipeline is empty; the block
   // does not enforce it, and the stages read the registers directly without a copy.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff     <= CW'(jvm_pkg::RST_X_MIN);
         x_max_ff     <= CW'(jvm_pkg::RST_X_MAX);
         x_mid_ff     <= CW'(jvm_pkg::RST_X_MID);
         y_min_ff     <= CW'(jvm_pkg::RST_Y_MIN);
         y_max_ff     <= CW'(jvm_pkg::RST_Y_MAX);
         y_mid_ff     <= CW'(jvm_pkg::RST_Y_MID);
         deadband_ff  <= jvm_pkg::DEADBAND_BITS'(jvm_pkg::RST_DEADBAND);
         fast_mode_ff <= 1'(jvm_pkg::RST_FAST_MODE);
      end else if (csr_write) begin
         unique case (jvm_pkg::csr_index_type'(csr_index))
            jvm_pkg::CSR_X_MIN:     x_min_ff     <= CW'(csr_wdata);
            jvm_pkg::CSR_X_MAX:     x_max_ff     <= CW'(csr_wdata);
            jvm_pkg::CSR_X_MID:     x_mid_ff     <= CW'(csr_wdata);
            jvm_pkg::CSR_Y_MIN:     y_min_ff     <= CW'(csr_wdata);
            jvm_pkg::CSR_Y_MAX:     y_max_ff     <= CW'(csr_wdata);
            jvm_pkg::CSR_Y_MID:     y_mid_ff     <= CW'(csr_wdata);
            jvm_pkg::CSR_DEADBAND:  deadband_ff  <= csr_wdata[jvm_pkg::DEADBAND_BITS-1:0];
            jvm_pkg::CSR_FAST_MODE: fast_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Per axis: distance and half-range are registered first, then the gain product.
   jvm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .sample    (req_x_sample),
      .cal_min   (x_min_ff),
      .cal_mid   (x_mid_ff),
      .cal_max   (x_max_ff),
      .fast_mode (fast_mode_ff),
      .out_valid (fx_valid),
      .out_above (fx_above),
      .out_num   (fx_num),
      .out_range (fx_range)
   );

   jvm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .sample    (req_y_sample),
      .cal_min   (y_min_ff),
      .cal_mid   (y_mid_ff),
      .cal_max   (y_max_ff),
      .fast_mode (fast_mode_ff),
      .out_valid (fy_valid),
      .out_above (fy_above),
      .out_num   (fy_num),
      .out_range (fy_range)
   );

   // One divider per axis, NW stages each; the side flag rides as the tag.
   jvm_div #(.NW(NW), .DW(CW), .TW(1)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fx_valid),
      .in_num    (fx_num),
      .in_den    (fx_range),
      .in_tag    (fx_above),
      .out_valid (dx_valid),
      .out_quo   (dx_quo),
      .out_tag   (dx_above)
   );

   jvm_div #(.NW(NW), .DW(CW), .TW(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fy_valid),
      .in_num    (fy_num),
      .in_den    (fy_range),
      .in_tag    (fy_above),
      .out_valid (dy_valid),
      .out_quo   (dy_quo),
      .out_tag   (dy_above)
   );

   // Final cycle: deadband, offset, sign and saturation into the output
   // register that drives the response strobe.
   jvm_back #(.NW(NW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .valid_x   (dx_valid),
      .valid_y   (dy_valid),
      .q_x       (dx_quo),
      .q_y       (dy_quo),
      .above_x   (dx_above),
      .above_y   (dy_above),
      .deadband  (deadband_ff),
      .out_valid (rsp_valid),
      .vel_x     (rsp_vel_x),
      .vel_y     (rsp_vel_y)
   );

endmodule
